[hdl/sawfr_pkg.sv]
// Shared types and constants for the stop-and-wait frame receiver.
package sawfr_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned LEN_W = 6;
    localparam int unsigned SEQ_W = 4;
    localparam int unsigned TYPE_W = 6;

    localparam logic [1:0] CFG_START_DELIM = 2'd0;
    localparam logic [1:0] CFG_DATA_TYPE = 2'd1;
    localparam logic [1:0] CFG_END_TYPE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DUP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END = 3'd4;

    typedef struct packed {
        logic [7:0]        start_delimiter;
        logic [TYPE_W-1:0] data_type_code;
        logic [TYPE_W-1:0] end_type_code;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   payload_length;
        logic [LEN_W-1:0]   byte_count;
        logic [SEQ_W-1:0]   current_seq;
        logic [7:0]         parity_acc;
        logic [SEQ_W-1:0]   accepted_seq;
        logic               accepted_valid;
    } rx_state_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [7:0]        payload_byte;
        logic [SEQ_W-1:0]  frame_seq;
        logic              last;
    } rx_result_t;

endpackage

[hdl/stop_and_wait_frame_receiver.sv]
// Top level of the stop-and-wait frame receiver with XOR parity check.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata rx_byte, tuser frame_start
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata payload_byte, frame_seq; tuser kind
//  cfg       in   cfg_we                         cfg_addr, cfg_wdata
//
// One byte is taken per cycle unless the output stalls; its result is loaded
// into the output register with the transaction, set by a single pass through the parser.
// Reset returns the parser to idle, clears the accepted sequence and loads
// the register defaults. A stalled output holds its result; the input is
// taken again in the same cycle the held result leaves.
module stop_and_wait_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_seq, [15:12] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    sawfr_pkg::cfg_t       cfg_reg;
    sawfr_pkg::rx_state_t  st_reg;
    sawfr_pkg::rx_state_t  st_next;
    sawfr_pkg::rx_result_t res;
    sawfr_pkg::rx_result_t out_reg;
    logic                  in_accept;

    assign s_axis_tready = !out_reg.valid || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    sawfr_parse u_parse (
        .cfg         (cfg_reg),
        .st          (st_reg),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .st_next     (st_next),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delimiter <= 8'd126;
            cfg_reg.data_type_code <= 6'd1;
            cfg_reg.end_type_code <= 6'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sawfr_pkg::CFG_START_DELIM: cfg_reg.start_delimiter <= cfg_wdata;
                sawfr_pkg::CFG_DATA_TYPE:   cfg_reg.data_type_code <= cfg_wdata[5:0];
                sawfr_pkg::CFG_END_TYPE:    cfg_reg.end_type_code <= cfg_wdata[5:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (in_accept)
        begin
            st_reg <= st_next;
        end
    end

    // hold the result until taken; load a new one on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (in_accept)
        begin
            out_reg <= res;
        end
        else if (m_axis_tready)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata = {4'd0, out_reg.frame_seq, out_reg.payload_byte};
    assign m_axis_tuser = out_reg.kind;
    assign m_axis_tlast = out_reg.last;

endmodule

[hdl/sawfr_parse.sv]
// Frame parser: next state and result for one received byte.
module sawfr_parse (
    input  sawfr_pkg::cfg_t       cfg,
    input  sawfr_pkg::rx_state_t  st,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    output sawfr_pkg::rx_state_t  st_next,
    output sawfr_pkg::rx_result_t res
);

    localparam logic [sawfr_pkg::PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [sawfr_pkg::PHASE_W-1:0] PH_HDR1 = 3'd1;
    localparam logic [sawfr_pkg::PHASE_W-1:0] PH_HDR2 = 3'd2;
    localparam logic [sawfr_pkg::PHASE_W-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [sawfr_pkg::PHASE_W-1:0] PH_PARITY = 3'd4;

    logic [sawfr_pkg::TYPE_W-1:0] hdr_type;
    logic [sawfr_pkg::LEN_W-1:0]  count_inc;
    logic [sawfr_pkg::SEQ_W-1:0]  hdr_seq;
    logic                         frame_new;

    assign hdr_type = rx_byte[5:0];
    assign hdr_seq = {st.current_seq[3:2], rx_byte[7:6]};
    assign count_inc = st.byte_count + 6'd1;
    assign frame_new = !st.accepted_valid || (st.accepted_seq != st.current_seq);

    always_comb
    begin
        st_next = st;
        res.valid = 1'b0;
        res.kind = sawfr_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.last = 1'b0;
        if (frame_start)
        begin
            st_next.phase = (rx_byte == cfg.start_delimiter) ? PH_HDR1 : PH_IDLE;
        end
        else
        begin
            case (st.phase)
                PH_HDR1:
                begin
                    st_next.payload_length = rx_byte[7:2];
                    st_next.current_seq = {rx_byte[1:0], 2'b00};
                    st_next.parity_acc = rx_byte;
                    st_next.phase = PH_HDR2;
                end
                PH_HDR2:
                begin
                    st_next.current_seq = hdr_seq;
                    st_next.parity_acc = st.parity_acc ^ rx_byte;
                    st_next.phase = PH_IDLE;
                    if (hdr_type == cfg.end_type_code)
                    begin
                        res.valid = 1'b1;
                        res.kind = sawfr_pkg::KIND_END;
                        res.last = 1'b1;
                    end
                    else if (hdr_type == cfg.data_type_code)
                    begin
                        st_next.byte_count = '0;
                        st_next.phase = (st.payload_length == '0) ? PH_PARITY : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    st_next.parity_acc = st.parity_acc ^ rx_byte;
                    st_next.byte_count = count_inc;
                    if (count_inc >= st.payload_length)
                    begin
                        st_next.phase = PH_PARITY;
                    end
                    if (frame_new)
                    begin
                        res.valid = 1'b1;
                        res.kind = sawfr_pkg::KIND_PAYLOAD;
                        res.payload_byte = rx_byte;
                    end
                end
                PH_PARITY:
                begin
                    st_next.phase = PH_IDLE;
                    res.valid = 1'b1;
                    res.last = 1'b1;
                    if (st.parity_acc != rx_byte)
                    begin
                        res.kind = sawfr_pkg::KIND_NACK;
                    end
                    else if (frame_new)
                    begin
                        res.kind = sawfr_pkg::KIND_COMMIT;
                        st_next.accepted_seq = st.current_seq;
                        st_next.accepted_valid = 1'b1;
                    end
                    else
                    begin
                        res.kind = sawfr_pkg::KIND_DUP;
                    end
                end
                default:
                begin
                    st_next.phase = PH_IDLE;
                end
            endcase
        end
        res.frame_seq = st_next.current_seq;
    end

endmodule
